// ----- rtl/dstq_pkg.sv -----
package dstq_pkg;

  localparam int DSTQ_DEPTH    = 16;
  localparam int DSTQ_ID_COUNT = 64;

  localparam int CMD_W = 3;
  localparam int ID_W  = 6;
  localparam int DLY_W = 32;
  localparam int DL_W  = 48;
  localparam int ST_W  = 2;

  localparam logic [CMD_W-1:0] CMD_ADD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_ARMED = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ID_W-1:0]  timer_id;
    logic [DLY_W-1:0] delay_us;
    logic [DL_W-1:0]  now_us;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [ID_W-1:0]  result_id;
    logic [DLY_W-1:0] remaining_us;
    logic             overdue;
    logic             head_changed;
  } out_word_t;

  // Contents of one queue slot.
  typedef struct packed {
    logic [DL_W-1:0] deadline;
    logic [ID_W-1:0] id;
  } cell_t;

  // Operation broadcast to every slot of the chain.
  typedef struct packed {
    logic            add;
    logic            del;
    logic            pop;
    logic [DL_W-1:0] deadline;
    logic [ID_W-1:0] id;
  } cell_ctl_t;

endpackage

// ----- rtl/dstq_cell.sv -----
module dstq_cell (
  input  logic              clk,
  input  logic              en,
  input  dstq_pkg::cell_ctl_t ctl,
  input  logic              occ,
  input  dstq_pkg::cell_t   left_data,
  input  logic              left_take,
  input  logic              left_hit,
  input  dstq_pkg::cell_t   right_data,
  output dstq_pkg::cell_t   data,
  output logic              take,
  output logic              hit
);
  import dstq_pkg::*;

  cell_t data_r;
  cell_t data_nxt;
  logic  match;

  // The queue is sorted, so take is low for a prefix of the chain and high after it.
  assign take  = !occ || (data_r.deadline > ctl.deadline);
  assign match = occ && (data_r.id == ctl.id);
  assign hit   = left_hit || match;
  assign data  = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.add) begin
      if (left_take) begin
        data_nxt = left_data;
      end else if (take) begin
        data_nxt.deadline = ctl.deadline;
        data_nxt.id       = ctl.id;
      end
    end else if (ctl.pop || (ctl.del && hit)) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- rtl/deadline_sorted_timer_queue_unit.sv -----
// Deadline-sorted timer queue.
// Input channel in_valid/in_ready/in_data carries one command word: add, delete,
// pop first, query next or clear all. Each command returns exactly one result word
// on out_valid/out_ready/out_data, in command order.
// Timers are held in a chain of DEPTH slots kept in ascending deadline order; an
// add computes now plus delay, and every slot compares itself against the new
// deadline and shifts right in the same cycle. Delete and pop shift slots left.
// A command runs in two steps: the accept step registers the word and forms the
// deadline sum, and the execute step does the slot update and the result. The unit
// takes no new word until the execute step of the last one is done.
// out_valid rises when the execute step completes and the result word is registered.
// The result sits in an output register, so the next word is accepted while it
// waits; if the receiver stalls, the following command holds in its execute
// step until the output register frees up.
// Reset (rst_n low, synchronous) empties the queue and disarms every id; no
// clearing pass is needed and the unit is ready the cycle after reset.
module deadline_sorted_timer_queue_unit #(
  parameter int DEPTH    = dstq_pkg::DSTQ_DEPTH,
  parameter int ID_COUNT = dstq_pkg::DSTQ_ID_COUNT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dstq_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dstq_pkg::out_word_t out_data
);
  import dstq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ARM_N = (ID_COUNT < (1 << ID_W)) ? ID_COUNT : (1 << ID_W);
  localparam int ARM_W = $clog2(ARM_N);
  localparam logic [ID_W:0]  ARM_LIM = (ID_W + 1)'(ARM_N);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t              state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [ID_W-1:0]     tid_r;
  logic [DL_W-1:0]     now_r;
  logic [DL_W-1:0]     dl_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ARM_N-1:0]    armed_r, armed_nxt;
  logic                out_valid_r;
  out_word_t           out_data_r, res;

  logic                accept, fire;
  logic                empty, full, id_in_range, id_armed;
  logic                do_add, do_del, do_pop;
  logic [DL_W:0]       diff;
  logic                head_later;
  cell_ctl_t           ctl;

  cell_t               cell_q [DEPTH];
  logic [DEPTH-1:0]    take;
  logic [DEPTH-1:0]    hit;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign fire     = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data.command;
      tid_r <= in_data.timer_id;
      now_r <= in_data.now_us;
      dl_r  <= in_data.now_us + {{(DL_W - DLY_W){1'b0}}, in_data.delay_us};
    end
  end

  assign empty       = (count_r == '0);
  assign full        = (count_r == CNT_FULL);
  assign id_in_range = ({1'b0, tid_r} < ARM_LIM);
  assign id_armed    = id_in_range && armed_r[tid_r[ARM_W-1:0]];

  assign do_add = (cmd_r == CMD_ADD) && id_in_range && !id_armed && !full;
  assign do_del = (cmd_r == CMD_DEL) && id_armed;
  assign do_pop = (cmd_r == CMD_POP) && !empty;

  assign ctl.add      = do_add;
  assign ctl.del      = do_del;
  assign ctl.pop      = do_pop;
  assign ctl.deadline = dl_r;
  assign ctl.id       = tid_r;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      cell_t left_d, right_d;
      logic  left_t, left_h, occ;

      assign occ = (count_r > CNT_W'(gi));
      if (gi == 0) begin : g_first
        assign left_d = cell_q[gi];
        assign left_t = 1'b0;
        assign left_h = 1'b0;
      end else begin : g_mid
        assign left_d = cell_q[gi-1];
        assign left_t = take[gi-1];
        assign left_h = hit[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_d = cell_q[gi];
      end else begin : g_inner
        assign right_d = cell_q[gi+1];
      end

      dstq_cell u_cell (
        .clk        (clk),
        .en         (fire),
        .ctl        (ctl),
        .occ        (occ),
        .left_data  (left_d),
        .left_take  (left_t),
        .left_hit   (left_h),
        .right_data (right_d),
        .data       (cell_q[gi]),
        .take       (take[gi]),
        .hit        (hit[gi])
      );
    end
  endgenerate

  // Borrow in the top bit tells whether the head deadline has passed; zero means due now.
  assign diff       = {1'b0, cell_q[0].deadline} - {1'b0, now_r};
  assign head_later = !diff[DL_W] && (diff[DL_W-1:0] != '0);

  always_comb begin
    res       = '0;
    count_nxt = count_r;
    armed_nxt = armed_r;
    unique case (cmd_r)
      CMD_ADD: begin
        if (id_armed) begin
          res.status = ST_ARMED;
        end else if (id_in_range && full) begin
          res.status = ST_FULL;
        end else if (do_add) begin
          res.head_changed                = take[0];
          count_nxt                       = count_r + 1'b1;
          armed_nxt[tid_r[ARM_W-1:0]]     = 1'b1;
        end
      end
      CMD_DEL: begin
        if (do_del) begin
          count_nxt                   = count_r - 1'b1;
          armed_nxt[tid_r[ARM_W-1:0]] = 1'b0;
        end
      end
      CMD_POP: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.result_id                         = cell_q[0].id;
          count_nxt                             = count_r - 1'b1;
          armed_nxt[cell_q[0].id[ARM_W-1:0]]    = 1'b0;
        end
      end
      CMD_QUERY: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else if (head_later) begin
          res.remaining_us = (diff[DL_W-1:DLY_W] != '0) ? '1 : diff[DLY_W-1:0];
        end else begin
          res.overdue = 1'b1;
        end
      end
      CMD_CLEAR: begin
        count_nxt = '0;
        armed_nxt = '0;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      armed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        count_r     <= count_nxt;
        armed_r     <= armed_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/dstq_checker.sv -----
module dstq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input dstq_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input dstq_pkg::out_word_t out_data
);
  import dstq_pkg::*;

  // A held result word must not change until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Each command occupies the unit for its execute step.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted during execute step");

  // An empty-queue result carries no other information.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY) |->
      (out_data.result_id == '0) && (out_data.remaining_us == '0) &&
      !out_data.overdue && !out_data.head_changed)
    else $error("empty result with nonzero fields");

  // An overdue head has no time left.
  a_overdue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overdue |->
      (out_data.remaining_us == '0) && (out_data.status == ST_OK) &&
      (out_data.result_id == '0))
    else $error("overdue result with remaining time");

  // Only a successful add can report a new head.
  a_head_changed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.head_changed |->
      (out_data.status == ST_OK) && (out_data.result_id == '0) &&
      !out_data.overdue && (out_data.remaining_us == '0))
    else $error("head change flagged outside an add");

endmodule

bind deadline_sorted_timer_queue_unit dstq_checker u_dstq_checker (.*);
